// ----- design/clfsw_pkg.sv -----
// ----------------------------------------------------------------------------
// clfsw_pkg
// Shared types and constants for the code list format selector writer.
// ----------------------------------------------------------------------------
`default_nettype none

package clfsw_pkg;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int GID_W  = 16;
  localparam int LEN_W  = 11;

  localparam logic [OP_W-1:0] OP_CODE = 2'd0;
  localparam logic [OP_W-1:0] OP_SUPP = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [BYTE_W-1:0] SUPP_FLAG = 8'h80;
  localparam logic [BYTE_W-1:0] FMT_MASK  = 8'h7f;
  localparam logic [BYTE_W-1:0] EXTRA_MAX = 8'd255;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] code;
    logic [GID_W-1:0]  gid;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_encoding;
    logic [LEN_W-1:0]  total_length;
  } res_t;

endpackage

`default_nettype wire

// ----- design/clfsw_fifo.sv -----
// ----------------------------------------------------------------------------
// clfsw_fifo
// Two-entry register queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module clfsw_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/clfsw_front.sv -----
// ----------------------------------------------------------------------------
// clfsw_front
// Accepts requests, discards unused operation codes, and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module clfsw_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [clfsw_pkg::OP_W-1:0]   operation,
  input  wire logic [clfsw_pkg::BYTE_W-1:0] code_value,
  input  wire logic [clfsw_pkg::GID_W-1:0]  glyph_id,
  output logic                          cmd_valid,
  input  wire logic                     cmd_pop,
  output clfsw_pkg::cmd_t               cmd
);
  import clfsw_pkg::*;

  logic q_full;
  logic q_empty;
  logic keep;
  cmd_t in_cmd;

  always_comb begin
    unique case (operation) inside
      OP_CODE, OP_SUPP, OP_READ: keep = 1'b1;
      default:                   keep = 1'b0;
    endcase
  end

  assign in_cmd.op   = operation;
  assign in_cmd.code = code_value;
  assign in_cmd.gid  = glyph_id;

  assign full      = q_full;
  assign cmd_valid = !q_empty;

  // A request with an unused operation code is taken but never queued.
  clfsw_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && keep),
    .wr_data (in_cmd),
    .full    (q_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .empty   (q_empty)
  );

endmodule

`default_nettype wire

// ----- design/clfsw_back.sv -----
// ----------------------------------------------------------------------------
// clfsw_back
// Stores codes, runs and supplements, and serializes the encoding on reads.
// ----------------------------------------------------------------------------
`default_nettype none

module clfsw_back #(
  parameter int MAX_CODES       = 255,
  parameter int MAX_SUPPLEMENTS = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire clfsw_pkg::cmd_t cmd,
  output logic             cmd_pop,
  input  wire logic        res_full,
  output logic             res_push,
  output clfsw_pkg::res_t  res
);
  import clfsw_pkg::*;

  localparam int CCW = $clog2(MAX_CODES + 1);
  localparam int SCW = $clog2(MAX_SUPPLEMENTS + 1);
  localparam int CIW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
  localparam int SIW = (MAX_SUPPLEMENTS > 1) ? $clog2(MAX_SUPPLEMENTS) : 1;
  localparam int SUPP_W = BYTE_W + GID_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  localparam logic [1:0] PART_CODE = 2'd0;
  localparam logic [1:0] PART_HIGH = 2'd1;
  localparam logic [1:0] PART_LOW  = 2'd2;

  logic [BYTE_W-1:0] code_mem  [MAX_CODES];
  logic [BYTE_W-1:0] first_mem [MAX_CODES];
  logic [BYTE_W-1:0] extra_mem [MAX_CODES];
  logic [SUPP_W-1:0] supp_mem  [MAX_SUPPLEMENTS];

  logic [BYTE_W-1:0] code_rd;
  logic [BYTE_W-1:0] first_rd;
  logic [BYTE_W-1:0] extra_rd;
  logic [SUPP_W-1:0] supp_rd;

  logic              state;
  logic [CCW-1:0]    code_count;
  logic [CCW-1:0]    run_count;
  logic [SCW-1:0]    supp_count;
  logic [LEN_W-1:0]  read_position;
  logic [SIW-1:0]    supp_index;
  logic [1:0]        supp_part;
  logic [BYTE_W-1:0] last_code;
  logic [BYTE_W-1:0] cur_extra;

  logic              take;
  logic              append_ok;
  logic              code_we;
  logic              supp_we;
  logic              new_run;
  logic [CCW-1:0]    rc_m1;
  logic [CIW-1:0]    run_widx;
  logic [BYTE_W-1:0] extra_wd;
  logic              fmt1;
  logic              has_supp;
  logic [LEN_W-1:0]  body_len;
  logic [LEN_W-1:0]  supp_len;
  logic [LEN_W-1:0]  total;
  logic [LEN_W-1:0]  body_off;
  logic [LEN_W-1:0]  pos_next;
  logic              is_last;
  logic              in_supp_data;
  logic [BYTE_W-1:0] byte_val;
  logic              emit;

  // ---------------- Request decode ----------------
  assign take      = (state == ST_IDLE) && cmd_valid;
  assign cmd_pop   = take;
  assign append_ok = (read_position == '0);
  assign code_we   = take && (cmd.op == OP_CODE) && append_ok
                     && (code_count < CCW'(MAX_CODES));
  assign supp_we   = take && (cmd.op == OP_SUPP) && append_ok
                     && (supp_count < SCW'(MAX_SUPPLEMENTS));

  // A run continues while codes ascend by one and its extra count has room.
  assign new_run  = (run_count == '0)
                    || (({1'b0, last_code} + 9'd1) != {1'b0, cmd.code})
                    || (cur_extra == EXTRA_MAX);
  assign rc_m1    = run_count - CCW'(1);
  assign run_widx = new_run ? run_count[CIW-1:0] : rc_m1[CIW-1:0];
  assign extra_wd = new_run ? '0 : cur_extra + 8'd1;

  // ---------------- Length and format ----------------
  assign fmt1     = (LEN_W'(code_count) > (LEN_W'(run_count) << 1));
  assign has_supp = (supp_count != '0);
  assign body_len = fmt1 ? (LEN_W'(run_count) << 1) + LEN_W'(1)
                         : LEN_W'(code_count) + LEN_W'(1);
  assign supp_len = has_supp ? (LEN_W'(supp_count) << 1) + LEN_W'(supp_count)
                               + LEN_W'(1)
                             : '0;
  assign total    = body_len + LEN_W'(1) + supp_len;
  assign body_off = read_position - LEN_W'(2);
  assign pos_next = read_position + LEN_W'(1);
  assign is_last  = (pos_next >= total);
  assign in_supp_data = (read_position > body_len + LEN_W'(1));

  // ---------------- Stores ----------------
  // Read addresses follow the read position, so data is ready in the cycle
  // after a read request is taken.
  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[code_count[CIW-1:0]] <= cmd.code;
    end
    code_rd <= code_mem[body_off[CIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (code_we && new_run) begin
      first_mem[run_widx] <= cmd.code;
    end
    first_rd <= first_mem[body_off[CIW:1]];
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      extra_mem[run_widx] <= extra_wd;
    end
    extra_rd <= extra_mem[body_off[CIW:1]];
  end

  always_ff @(posedge clk) begin
    if (supp_we) begin
      supp_mem[supp_count[SIW-1:0]] <= {cmd.code, cmd.gid};
    end
    supp_rd <= supp_mem[supp_index];
  end

  // ---------------- Output byte ----------------
  always_comb begin
    if (read_position == LEN_W'(0)) begin
      byte_val = (has_supp ? SUPP_FLAG : 8'h00)
                 | (FMT_MASK & (fmt1 ? 8'h01 : 8'h00));
    end else if (read_position == LEN_W'(1)) begin
      byte_val = fmt1 ? 8'(run_count) : 8'(code_count);
    end else if (read_position <= body_len) begin
      if (!fmt1) begin
        byte_val = code_rd;
      end else begin
        byte_val = read_position[0] ? extra_rd : first_rd;
      end
    end else if (read_position == body_len + LEN_W'(1)) begin
      byte_val = 8'(supp_count);
    end else begin
      case (supp_part)
        PART_CODE: byte_val = supp_rd[SUPP_W-1:GID_W];
        PART_HIGH: byte_val = supp_rd[GID_W-1:BYTE_W];
        default:   byte_val = supp_rd[BYTE_W-1:0];
      endcase
    end
  end

  assign emit     = (state == ST_EMIT) && !res_full;
  assign res_push = emit;
  assign res.out_byte         = byte_val;
  assign res.last_of_encoding = is_last;
  assign res.total_length     = total;

  // ---------------- Control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      code_count    <= '0;
      run_count     <= '0;
      supp_count    <= '0;
      read_position <= '0;
      supp_index    <= '0;
      supp_part     <= PART_CODE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take && (cmd.op == OP_READ)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (code_we) begin
        code_count <= code_count + CCW'(1);
        if (new_run) begin
          run_count <= run_count + CCW'(1);
        end
      end
      if (supp_we) begin
        supp_count <= supp_count + SCW'(1);
      end

      if (emit) begin
        if (is_last) begin
          code_count    <= '0;
          run_count     <= '0;
          supp_count    <= '0;
          read_position <= '0;
          supp_index    <= '0;
          supp_part     <= PART_CODE;
        end else begin
          read_position <= pos_next;
          if (in_supp_data) begin
            if (supp_part == PART_LOW) begin
              supp_part  <= PART_CODE;
              supp_index <= supp_index + SIW'(1);
            end else begin
              supp_part <= supp_part + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      last_code <= cmd.code;
      cur_extra <= extra_wd;
    end
  end

  // ---------------- Assertions ----------------
  a_runs_within_codes: assert property (@(posedge clk) disable iff (rst)
    run_count <= code_count)
    else $error("run count exceeds code count");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last_of_encoding) |=>
      (code_count == '0) && (supp_count == '0) && (read_position == '0))
    else $error("encoding not cleared after its final byte");

  a_frozen_in_readout: assert property (@(posedge clk) disable iff (rst)
    ((read_position != '0) && !res_push) |=>
      ($stable(code_count) && $stable(supp_count) && $stable(run_count)))
    else $error("lists changed during readout");

  a_read_goes_to_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && (cmd.op == OP_READ)) |=> (state == ST_EMIT))
    else $error("read request did not reach the emit step");

endmodule

`default_nettype wire

// ----- design/code_list_format_selector_writer_top.sv -----
// ----------------------------------------------------------------------------
// code_list_format_selector_writer_top
// Collects one encoding and serializes it in the smaller of two formats.
// ----------------------------------------------------------------------------
// Usage: requests enter through push/full. Operation 0 appends a code byte,
// operation 1 appends a supplement (code_value, glyph_id), and operation 2
// asks for the next serialized byte; operation 3 is taken and ignored.
// Only reads produce results, which leave through empty/pop, oldest first,
// each with the final-byte flag and the total length of the encoding.
// Appends are absorbed at one per cycle while no read byte is pending in the
// back end. A read passes through the back end in order: the registered
// store read addressed by the read position, then forming and queueing the
// byte; the back end takes no new request until that byte is queued, and
// the byte reaches the result ports through the result queue.
// After the final byte all counts clear for the next encoding; appends
// that arrive once readout has started are dropped.
// Reset empties both queues and leaves an empty encoding. When the receiver
// stops popping, the result queue fills, the back end holds its byte, the
// request queue fills and full rises; no request or result is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module code_list_format_selector_writer_top #(
  parameter int MAX_CODES       = 255,
  parameter int MAX_SUPPLEMENTS = 255
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [clfsw_pkg::OP_W-1:0]    operation,
  input  wire logic [clfsw_pkg::BYTE_W-1:0]  code_value,
  input  wire logic [clfsw_pkg::GID_W-1:0]   glyph_id,
  output logic                               empty,
  input  wire logic                          pop,
  output logic      [clfsw_pkg::BYTE_W-1:0]  out_byte,
  output logic                               last_of_encoding,
  output logic      [clfsw_pkg::LEN_W-1:0]   total_length
);
  import clfsw_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  clfsw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .code_value (code_value),
    .glyph_id   (glyph_id),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd)
  );

  clfsw_back #(
    .MAX_CODES       (MAX_CODES),
    .MAX_SUPPLEMENTS (MAX_SUPPLEMENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  clfsw_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign out_byte         = res_out.out_byte;
  assign last_of_encoding = res_out.last_of_encoding;
  assign total_length     = res_out.total_length;

endmodule

`default_nettype wire

// ----- sim/code_list_format_selector_writer_top_test.sv -----
// ----------------------------------------------------------------------------
// code_list_format_selector_writer_top_test
// Checks the serialized bytes, final-byte flags and total lengths against an in-bench prediction.
// ----------------------------------------------------------------------------
// Directed encodings cover the empty encoding, the supplement flag, both
// formats and appends during readout. Random encodings follow, built from
// runs of consecutive codes with supplements mixed in, including lists that
// overflow both stores. Both sides idle in random bursts, the receiver holds
// off long enough to fill the block once, and the sender drains once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module code_list_format_selector_writer_top_test;
  import clfsw_pkg::*;

  localparam int                CODE_CAP  = 255;
  localparam int                SUPP_CAP  = 255;
  localparam logic [OP_W-1:0]   OP_NONE   = 2'd3;
  localparam int                RANDOM_ITEMS = 1500;
  localparam int                HOLD_CYCLES  = 300;

  class encoding_scoreboard;
    logic [BYTE_W-1:0] code_mem [CODE_CAP];
    logic [BYTE_W-1:0] run_start [CODE_CAP];
    logic [BYTE_W-1:0] run_extra [CODE_CAP];
    logic [BYTE_W+GID_W-1:0] supp_mem [SUPP_CAP];
    int   n_codes;
    int   n_runs;
    int   n_supps;
    int   rd_pos;
    res_t expected_bytes [$];
    int   mismatches;

    task report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    function bit run_format();
      return n_codes > 2 * n_runs;
    endfunction

    function int body_bytes();
      return run_format() ? 1 + 2 * n_runs : 1 + n_codes;
    endfunction

    function int encoding_bytes();
      int t;
      t = 1 + body_bytes();
      if (n_supps > 0) t += 1 + 3 * n_supps;
      return t;
    endfunction

    function int bytes_left();
      return encoding_bytes() - rd_pos;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function logic [BYTE_W-1:0] byte_at(int p);
      int b;
      int k;
      int q;
      logic [BYTE_W-1:0] fmt;
      logic [BYTE_W+GID_W-1:0] entry;
      b = body_bytes();
      if (p == 0) begin
        fmt = run_format() ? 8'd1 : 8'd0;
        if (n_supps > 0) fmt = fmt | SUPP_FLAG;
        return fmt;
      end
      if (p == 1) return run_format() ? BYTE_W'(n_runs) : BYTE_W'(n_codes);
      if (p <= b) begin
        k = p - 2;
        if (!run_format()) return code_mem[k];
        return k[0] ? run_extra[k >> 1] : run_start[k >> 1];
      end
      if (p == b + 1) return BYTE_W'(n_supps);
      q = p - b - 2;
      entry = supp_mem[q / 3];
      case (q % 3)
        0: return entry[23:16];
        1: return entry[15:8];
        default: return entry[7:0];
      endcase
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] code,
                               logic [GID_W-1:0] gid);
      res_t r;
      int total;
      if (op == OP_CODE) begin
        if (rd_pos != 0 || n_codes >= CODE_CAP) return;
        // A code extends the open run only if it follows the previous code
        // without wrapping and the run still has room.
        if (n_runs == 0 || int'(code_mem[n_codes-1]) + 1 != int'(code) ||
            run_extra[n_runs-1] == EXTRA_MAX) begin
          if (n_runs < CODE_CAP) begin
            run_start[n_runs] = code;
            run_extra[n_runs] = '0;
            n_runs++;
          end
        end else begin
          run_extra[n_runs-1] = run_extra[n_runs-1] + 1'b1;
        end
        code_mem[n_codes] = code;
        n_codes++;
      end else if (op == OP_SUPP) begin
        if (rd_pos != 0 || n_supps >= SUPP_CAP) return;
        supp_mem[n_supps] = {code, gid};
        n_supps++;
      end else if (op == OP_READ) begin
        total = encoding_bytes();
        r.out_byte = byte_at(rd_pos);
        r.last_of_encoding = (rd_pos + 1 >= total);
        r.total_length = LEN_W'(total);
        expected_bytes.push_back(r);
        if (r.last_of_encoding) begin
          n_codes = 0;
          n_runs = 0;
          n_supps = 0;
          rd_pos = 0;
        end else begin
          rd_pos++;
        end
      end
    endfunction

    task check_byte(logic [BYTE_W-1:0] b, logic last, logic [LEN_W-1:0] len);
      res_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected result byte", b, -1);
        return;
      end
      want = expected_bytes.pop_front();
      if (b !== want.out_byte) report_mismatch("out_byte", b, want.out_byte);
      if (last !== want.last_of_encoding)
        report_mismatch("last_of_encoding", last, want.last_of_encoding);
      if (len !== want.total_length) report_mismatch("total_length", len, want.total_length);
    endtask

    task flag_leftovers();
      if (expected_bytes.size() != 0)
        report_mismatch("results never delivered", 0, expected_bytes.size());
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic [OP_W-1:0]     operation;
  logic [BYTE_W-1:0]   code_value;
  logic [GID_W-1:0]    glyph_id;
  logic                empty;
  logic                pop;
  logic [BYTE_W-1:0]   out_byte;
  logic                last_of_encoding;
  logic [LEN_W-1:0]    total_length;

  encoding_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_pop = 1'b0;
  int sent_count = 0;
  int idle_stop = 1_000_000;
  logic [BYTE_W-1:0] next_code = '0;
  int run_left = 0;

  code_list_format_selector_writer_top uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .code_value(code_value),
    .glyph_id(glyph_id),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .last_of_encoding(last_of_encoding),
    .total_length(total_length)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_request(operation, code_value, glyph_id);
      if (pop && !empty) sb.check_byte(out_byte, last_of_encoding, total_length);
    end
  end

  task automatic pause_sender(int n);
    push <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] code,
                              logic [GID_W-1:0] gid);
    // The last part of the run goes without idling on either side.
    if (sent_count >= idle_stop) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 11));
    push <= 1'b1;
    operation <= op;
    code_value <= code;
    glyph_id <= gid;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_read();
    send_request(OP_READ, BYTE_W'($urandom), GID_W'($urandom));
  endtask

  // Codes come in runs of consecutive values so that format 1 wins often.
  task automatic send_code();
    if (run_left == 0) begin
      next_code = BYTE_W'($urandom);
      run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
    end
    send_request(OP_CODE, next_code, GID_W'($urandom));
    next_code = next_code + 1'b1;
    run_left--;
  endtask

  task automatic send_noise();
    send_request(OP_NONE, BYTE_W'($urandom), GID_W'($urandom));
  endtask

  task automatic send_encoding(int codes, int supps, bit hold_on_readout);
    int reads;
    int cut;
    while (codes > 0 || supps > 0) begin
      if ($urandom_range(0, 15) == 0) send_noise();
      if (supps > 0 && (codes == 0 || $urandom_range(0, 3) == 0)) begin
        send_request(OP_SUPP, BYTE_W'($urandom), GID_W'($urandom));
        supps--;
      end else begin
        send_code();
        codes--;
      end
    end
    reads = sb.bytes_left();
    if (hold_on_readout) hold_pop = 1'b1;
    // Now and then the readout is cut short, so the next appends are dropped.
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, reads) : 0;
    for (int i = 0; i < reads - cut; i++) begin
      case ($urandom_range(0, 19))
        0: send_code();
        1: send_request(OP_SUPP, BYTE_W'($urandom), GID_W'($urandom));
        2: send_noise();
        default: ;
      endcase
      send_read();
    end
  endtask

  initial begin
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_pop) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pop = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        pop <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int enc_index;
    int codes;
    int supps;
    int waited;
    int random_goal;
    rst = 1'b1;
    push = 1'b0;
    operation = OP_CODE;
    code_value = '0;
    glyph_id = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty encoding: format 0 with a zero count.
    send_request(OP_READ, 8'h00, 16'h0000);
    send_request(OP_READ, 8'hff, 16'hffff);
    // Supplement only, with an unused operation that must be ignored.
    send_request(OP_SUPP, 8'hff, 16'hffff);
    send_request(OP_NONE, 8'ha5, 16'h5a5a);
    repeat (6) send_read();
    // One run of three codes picks format 1; appends during readout are dropped.
    send_request(OP_CODE, 8'h00, 16'hffff);
    send_request(OP_CODE, 8'h01, 16'h0000);
    send_request(OP_CODE, 8'h02, 16'h1234);
    send_request(OP_SUPP, 8'h00, 16'h0000);
    repeat (2) send_read();
    send_request(OP_CODE, 8'h40, 16'h0000);
    send_request(OP_SUPP, 8'h41, 16'hffff);
    repeat (6) send_read();

    random_goal = sent_count + RANDOM_ITEMS;
    idle_stop = random_goal - RANDOM_ITEMS / 7;
    enc_index = 0;
    while (sent_count < random_goal) begin
      enc_index++;
      if (enc_index == 4) begin
        codes = $urandom_range(256, 270);
        supps = $urandom_range(0, 2);
      end else if (enc_index == 8) begin
        codes = $urandom_range(0, 6);
        supps = $urandom_range(256, 262);
      end else begin
        codes = $urandom_range(0, 24);
        supps = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
      end
      send_encoding(codes, supps, enc_index == 8);
      if (enc_index == 6) begin
        push <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end
    end
    idle_on = 1'b0;

    push <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    sb.flag_leftovers();
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
